/* src/rbei_pkg.sv */
// Package for the regulator binding Euler integrator.
// Holds fixed-point constants, operand codes, the instruction type and the
// microcode table. No dependencies.
package rbei_pkg;

  localparam int VAL_W      = 48;
  localparam int FRAC_BITS  = 32;
  localparam int STEP_BITS  = 20;
  localparam int CNT_W      = STEP_BITS + 1;
  localparam int PC_W       = 7;
  localparam int RF_DEPTH   = 16;
  localparam int RF_AW      = 4;
  localparam int OPND_W     = 5;

  localparam logic [CNT_W-1:0] STEP_LIMIT = CNT_W'(1) << STEP_BITS;
  localparam logic [VAL_W-1:0] VAL_ONE    = VAL_W'(1) << FRAC_BITS;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BIND   = 3'd0;
  localparam logic [2:0] CFG_UNBIND = 3'd1;
  localparam logic [2:0] CFG_DEACT  = 3'd2;
  localparam logic [2:0] CFG_DT     = 3'd3;
  localparam logic [2:0] CFG_STEPS  = 3'd4;

  // Register file slots.
  localparam logic [OPND_W-1:0] R_X0  = 5'd0;
  localparam logic [OPND_W-1:0] R_X1  = 5'd1;
  localparam logic [OPND_W-1:0] R_X2  = 5'd2;
  localparam logic [OPND_W-1:0] R_X3  = 5'd3;
  localparam logic [OPND_W-1:0] R_P0  = 5'd4;
  localparam logic [OPND_W-1:0] R_P1  = 5'd5;
  localparam logic [OPND_W-1:0] R_REL = 5'd6;
  localparam logic [OPND_W-1:0] R_CAP = 5'd7;
  localparam logic [OPND_W-1:0] R_Q   = 5'd8;
  localparam logic [OPND_W-1:0] R_T0  = 5'd9;
  localparam logic [OPND_W-1:0] R_D0  = 5'd10;
  localparam logic [OPND_W-1:0] R_D1  = 5'd11;
  localparam logic [OPND_W-1:0] R_D2  = 5'd12;
  localparam logic [OPND_W-1:0] R_D3  = 5'd13;
  localparam logic [OPND_W-1:0] R_T1  = 5'd14;
  localparam logic [OPND_W-1:0] R_T2  = 5'd15;

  // Constant operands, selected when the top bit of the code is set.
  localparam logic [OPND_W-1:0] C_B    = 5'd16;
  localparam logic [OPND_W-1:0] C_U    = 5'd17;
  localparam logic [OPND_W-1:0] C_L    = 5'd18;
  localparam logic [OPND_W-1:0] C_DT   = 5'd19;
  localparam logic [OPND_W-1:0] C_ZERO = 5'd20;
  localparam logic [OPND_W-1:0] C_ONE  = 5'd21;
  localparam logic [OPND_W-1:0] C_X0   = 5'd22;

  // Microcode entry points.
  localparam logic [PC_W-1:0] PC_INIT_LAST = 7'd5;
  localparam logic [PC_W-1:0] PC_M0        = 7'd6;
  localparam logic [PC_W-1:0] PC_M1        = 7'd17;
  localparam logic [PC_W-1:0] PC_M2        = 7'd38;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [RF_AW-1:0]  dst;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic              last;
  } instr_t;

  function automatic instr_t mk(input op_e op, input logic [OPND_W-1:0] d,
                                input logic [OPND_W-1:0] a,
                                input logic [OPND_W-1:0] b, input logic last);
    instr_t r;
    r.op   = op;
    r.dst  = d[RF_AW-1:0];
    r.a    = a;
    r.b    = b;
    r.last = last;
    return r;
  endfunction

  // Microcode: shared set-up, then one Euler step of each model. The entry
  // flagged last closes a step.
  function automatic instr_t rbei_rom(input logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      // Set-up of a run.
      7'd0:  r = mk(OP_ADD, R_X0, C_X0, C_ZERO, 1'b0);
      7'd1:  r = mk(OP_ADD, R_X1, C_ZERO, C_ZERO, 1'b0);
      7'd2:  r = mk(OP_ADD, R_X2, C_ZERO, C_ZERO, 1'b0);
      7'd3:  r = mk(OP_ADD, R_X3, C_ZERO, C_ZERO, 1'b0);
      7'd4:  r = mk(OP_ADD, R_P0, C_ONE, C_ZERO, 1'b0);
      7'd5:  r = mk(OP_ADD, R_P1, C_ZERO, C_ZERO, 1'b0);
      // Monomer activator.
      7'd6:  r = mk(OP_MUL, R_REL, R_P1, C_L, 1'b0);
      7'd7:  r = mk(OP_MUL, R_CAP, R_P0, R_X0, 1'b0);
      7'd8:  r = mk(OP_SUB, R_D0, R_REL, R_CAP, 1'b0);
      7'd9:  r = mk(OP_SUB, R_T0, R_CAP, R_REL, 1'b0);
      7'd10: r = mk(OP_SUB, R_T1, R_REL, R_CAP, 1'b0);
      7'd11: r = mk(OP_MUL, R_T2, R_D0, C_DT, 1'b0);
      7'd12: r = mk(OP_ADD, R_X0, R_X0, R_T2, 1'b0);
      7'd13: r = mk(OP_MUL, R_T2, R_T1, C_DT, 1'b0);
      7'd14: r = mk(OP_ADD, R_P0, R_P0, R_T2, 1'b0);
      7'd15: r = mk(OP_MUL, R_T2, R_T0, C_DT, 1'b0);
      7'd16: r = mk(OP_ADD, R_P1, R_P1, R_T2, 1'b1);
      // Dimer activator.
      7'd17: r = mk(OP_MUL, R_REL, R_P1, C_L, 1'b0);
      7'd18: r = mk(OP_MUL, R_CAP, R_P0, R_X1, 1'b0);
      7'd19: r = mk(OP_MUL, R_T0, C_B, R_X0, 1'b0);
      7'd20: r = mk(OP_MUL, R_Q, R_T0, R_X0, 1'b0);
      7'd21: r = mk(OP_MUL, R_T0, C_U, R_X1, 1'b0);
      7'd22: r = mk(OP_ADD, R_T1, R_T0, R_T0, 1'b0);
      7'd23: r = mk(OP_ADD, R_T2, R_Q, R_Q, 1'b0);
      7'd24: r = mk(OP_SUB, R_D0, R_T1, R_T2, 1'b0);
      7'd25: r = mk(OP_SUB, R_D1, R_Q, R_T0, 1'b0);
      7'd26: r = mk(OP_SUB, R_D1, R_D1, R_CAP, 1'b0);
      7'd27: r = mk(OP_ADD, R_D1, R_D1, R_REL, 1'b0);
      7'd28: r = mk(OP_SUB, R_T0, R_CAP, R_REL, 1'b0);
      7'd29: r = mk(OP_SUB, R_T1, R_REL, R_CAP, 1'b0);
      7'd30: r = mk(OP_MUL, R_T2, R_D0, C_DT, 1'b0);
      7'd31: r = mk(OP_ADD, R_X0, R_X0, R_T2, 1'b0);
      7'd32: r = mk(OP_MUL, R_T2, R_D1, C_DT, 1'b0);
      7'd33: r = mk(OP_ADD, R_X1, R_X1, R_T2, 1'b0);
      7'd34: r = mk(OP_MUL, R_T2, R_T1, C_DT, 1'b0);
      7'd35: r = mk(OP_ADD, R_P0, R_P0, R_T2, 1'b0);
      7'd36: r = mk(OP_MUL, R_T2, R_T0, C_DT, 1'b0);
      7'd37: r = mk(OP_ADD, R_P1, R_P1, R_T2, 1'b1);
      // Tetramer activator.
      7'd38: r = mk(OP_MUL, R_REL, R_P1, C_L, 1'b0);
      7'd39: r = mk(OP_MUL, R_CAP, R_P0, R_X3, 1'b0);
      7'd40: r = mk(OP_ADD, R_T1, R_X0, R_X0, 1'b0);
      7'd41: r = mk(OP_ADD, R_T1, R_T1, R_X1, 1'b0);
      7'd42: r = mk(OP_ADD, R_T1, R_T1, R_X2, 1'b0);
      7'd43: r = mk(OP_ADD, R_T2, R_X1, R_X1, 1'b0);
      7'd44: r = mk(OP_ADD, R_T2, R_T2, R_X2, 1'b0);
      7'd45: r = mk(OP_ADD, R_T2, R_T2, R_X3, 1'b0);
      7'd46: r = mk(OP_MUL, R_Q, C_B, R_X0, 1'b0);
      7'd47: r = mk(OP_MUL, R_Q, R_Q, R_T1, 1'b0);
      7'd48: r = mk(OP_SUB, R_Q, C_ZERO, R_Q, 1'b0);
      7'd49: r = mk(OP_MUL, R_T0, C_U, R_T2, 1'b0);
      7'd50: r = mk(OP_ADD, R_D0, R_Q, R_T0, 1'b0);
      7'd51: r = mk(OP_MUL, R_T1, R_X0, R_X0, 1'b0);
      7'd52: r = mk(OP_MUL, R_T2, R_X0, R_X1, 1'b0);
      7'd53: r = mk(OP_MUL, R_Q, R_X0, R_X2, 1'b0);
      7'd54: r = mk(OP_SUB, R_T0, R_T1, R_T2, 1'b0);
      7'd55: r = mk(OP_MUL, R_T0, C_B, R_T0, 1'b0);
      7'd56: r = mk(OP_SUB, R_T1, R_X2, R_X1, 1'b0);
      7'd57: r = mk(OP_MUL, R_T1, C_U, R_T1, 1'b0);
      7'd58: r = mk(OP_ADD, R_D1, R_T0, R_T1, 1'b0);
      7'd59: r = mk(OP_SUB, R_T0, R_T2, R_Q, 1'b0);
      7'd60: r = mk(OP_MUL, R_T0, C_B, R_T0, 1'b0);
      7'd61: r = mk(OP_SUB, R_T1, R_X3, R_X2, 1'b0);
      7'd62: r = mk(OP_MUL, R_T1, C_U, R_T1, 1'b0);
      7'd63: r = mk(OP_ADD, R_D2, R_T0, R_T1, 1'b0);
      7'd64: r = mk(OP_MUL, R_T0, C_B, R_X2, 1'b0);
      7'd65: r = mk(OP_MUL, R_T0, R_T0, R_X0, 1'b0);
      7'd66: r = mk(OP_MUL, R_T1, C_U, R_X3, 1'b0);
      7'd67: r = mk(OP_SUB, R_D3, R_T0, R_T1, 1'b0);
      7'd68: r = mk(OP_SUB, R_D3, R_D3, R_CAP, 1'b0);
      7'd69: r = mk(OP_ADD, R_D3, R_D3, R_REL, 1'b0);
      7'd70: r = mk(OP_SUB, R_T0, R_CAP, R_REL, 1'b0);
      7'd71: r = mk(OP_SUB, R_T1, R_REL, R_CAP, 1'b0);
      7'd72: r = mk(OP_MUL, R_T2, R_D0, C_DT, 1'b0);
      7'd73: r = mk(OP_ADD, R_X0, R_X0, R_T2, 1'b0);
      7'd74: r = mk(OP_MUL, R_T2, R_D1, C_DT, 1'b0);
      7'd75: r = mk(OP_ADD, R_X1, R_X1, R_T2, 1'b0);
      7'd76: r = mk(OP_MUL, R_T2, R_D2, C_DT, 1'b0);
      7'd77: r = mk(OP_ADD, R_X2, R_X2, R_T2, 1'b0);
      7'd78: r = mk(OP_MUL, R_T2, R_D3, C_DT, 1'b0);
      7'd79: r = mk(OP_ADD, R_X3, R_X3, R_T2, 1'b0);
      7'd80: r = mk(OP_MUL, R_T2, R_T1, C_DT, 1'b0);
      7'd81: r = mk(OP_ADD, R_P0, R_P0, R_T2, 1'b0);
      7'd82: r = mk(OP_MUL, R_T2, R_T0, C_DT, 1'b0);
      7'd83: r = mk(OP_ADD, R_P1, R_P1, R_T2, 1'b1);
      default: r = mk(OP_ADD, R_T2, C_ZERO, C_ZERO, 1'b0);
    endcase
    return r;
  endfunction

endpackage

/* src/rbei_ram.sv */
// Generic register file RAM: one write port, two registered read ports.
// No dependencies.
module rbei_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* src/rbei_mul.sv */
// Iterative saturating fixed-point multiplier built on one 24x24 multiplier.
// Depends on rbei_pkg.
module rbei_mul
  import rbei_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] a_i,
  input  logic [VAL_W-1:0] b_i,
  output logic             done_o,
  output logic [VAL_W-1:0] p_o
);

  localparam int HALF_W = VAL_W / 2;
  localparam int ACC_W  = 2 * VAL_W;
  localparam int SH_W   = ACC_W - FRAC_BITS;

  typedef enum logic [1:0] {
    M_IDLE,
    M_ACC,
    M_FIN
  } mstate_e;

  mstate_e          state_q;
  logic [1:0]       cnt_q;
  logic             neg_q;
  logic [VAL_W-1:0] ma_q, mb_q;
  logic [ACC_W-1:0] acc_q;

  logic [HALF_W-1:0]  pa, pb;
  logic [VAL_W-1:0]   pp;
  logic [ACC_W-1:0]   pp_sh;
  logic [SH_W-1:0]    shifted, lim;
  logic [SH_W-1:0]    mag;

  // One partial product of the magnitude halves per cycle.
  always_comb begin
    pa = cnt_q[1] ? ma_q[VAL_W-1:HALF_W] : ma_q[HALF_W-1:0];
    pb = cnt_q[0] ? mb_q[VAL_W-1:HALF_W] : mb_q[HALF_W-1:0];
    pp = pa * pb;
    case (cnt_q)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd3:    pp_sh = ACC_W'(pp) << (2 * HALF_W);
      default: pp_sh = ACC_W'(pp) << HALF_W;
    endcase
  end

  // Drop the fraction bits, saturate the magnitude, then apply the sign.
  always_comb begin
    shifted = acc_q[ACC_W-1:FRAC_BITS];
    lim     = neg_q ? (SH_W'(1) << (VAL_W - 1)) : ((SH_W'(1) << (VAL_W - 1)) - SH_W'(1));
    mag     = (shifted > lim) ? lim : shifted;
    p_o     = neg_q ? (VAL_W'(0) - mag[VAL_W-1:0]) : mag[VAL_W-1:0];
    done_o  = (state_q == M_FIN);
  end

  // Sequencer and accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            state_q <= M_ACC;
            cnt_q   <= 2'd0;
          end
        end
        M_ACC: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= M_FIN;
          end
        end
        M_FIN: begin
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  // Operand magnitudes and accumulation need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      neg_q <= a_i[VAL_W-1] ^ b_i[VAL_W-1];
      ma_q  <= a_i[VAL_W-1] ? (VAL_W'(0) - a_i) : a_i;
      mb_q  <= b_i[VAL_W-1] ? (VAL_W'(0) - b_i) : b_i;
      acc_q <= '0;
    end else if (state_q == M_ACC) begin
      acc_q <= acc_q + pp_sh;
    end
  end

endmodule

/* src/regulator_binding_euler_integrator_top.sv */
// Regulator binding Euler integrator: microcoded sequencer over a register
// file, a shared saturating adder and the iterative multiplier.
// Depends on rbei_pkg, rbei_ram and rbei_mul.
// Each item runs the three models in turn; each run does the set-up, then
// step_count Euler steps (capped at STEP_LIMIT), each add or subtract taking a
// fetch and an execute state and each multiply also waiting on the multiplier.
// Throughput: one item at a time; a new item is taken only in the idle state.
// Reset: asynchronous, active low; restores the register defaults.
module regulator_binding_euler_integrator_top
  import rbei_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [46:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [46:0]      initial_monomer_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] active_fraction_monomer_o,
  output logic [VAL_W-1:0] active_fraction_dimer_o,
  output logic [VAL_W-1:0] active_fraction_tetramer_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_MULW,
    S_END,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [PC_W-1:0]  pc_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       model_q;
  logic             out_valid_q;

  logic [46:0]      bind_q, unbind_q, deact_q, x0_q;
  logic [32:0]      dt_q;
  logic [20:0]      steps_q;
  logic [VAL_W-1:0] p1_q, held0_q, held1_q;
  logic [VAL_W-1:0] out0_q, out1_q, out2_q;

  instr_t           instr;
  logic [CNT_W-1:0] n_eff;
  logic [VAL_W-1:0] rd_a, rd_b, opa, opb, alu_res, wdata;
  logic [VAL_W:0]   sum;
  logic             ram_we, mul_start, mul_done;
  logic [VAL_W-1:0] mul_p;
  logic [PC_W-1:0]  body_pc;

  function automatic logic [VAL_W-1:0] opnd(input logic [OPND_W-1:0] code,
                                            input logic [VAL_W-1:0] rd,
                                            input logic [46:0] b, input logic [46:0] u,
                                            input logic [46:0] l, input logic [32:0] dt,
                                            input logic [46:0] x0);
    logic [VAL_W-1:0] v;
    case (code)
      C_B:     v = VAL_W'(b);
      C_U:     v = VAL_W'(u);
      C_L:     v = VAL_W'(l);
      C_DT:    v = VAL_W'(dt);
      C_ONE:   v = VAL_ONE;
      C_X0:    v = VAL_W'(x0);
      C_ZERO:  v = '0;
      default: v = rd;
    endcase
    return v;
  endfunction

  assign instr       = rbei_rom(pc_q);
  assign n_eff       = (CNT_W'(steps_q) > STEP_LIMIT) ? STEP_LIMIT : CNT_W'(steps_q);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign active_fraction_monomer_o  = out0_q;
  assign active_fraction_dimer_o    = out1_q;
  assign active_fraction_tetramer_o = out2_q;

  // Operand selection and the saturating adder.
  always_comb begin
    opa = opnd(instr.a, rd_a, bind_q, unbind_q, deact_q, dt_q, x0_q);
    opb = opnd(instr.b, rd_b, bind_q, unbind_q, deact_q, dt_q, x0_q);
    if (instr.op == OP_SUB) begin
      sum = {opa[VAL_W-1], opa} - {opb[VAL_W-1], opb};
    end else begin
      sum = {opa[VAL_W-1], opa} + {opb[VAL_W-1], opb};
    end
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      alu_res = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      alu_res = sum[VAL_W-1:0];
    end
    ram_we    = (state_q == S_EXEC && instr.op != OP_MUL) || (state_q == S_MULW && mul_done);
    mul_start = (state_q == S_EXEC && instr.op == OP_MUL);
    wdata     = (state_q == S_MULW) ? mul_p : alu_res;
    case (model_q)
      2'd0:    body_pc = PC_M0;
      2'd1:    body_pc = PC_M1;
      default: body_pc = PC_M2;
    endcase
  end

  rbei_ram #(
    .WIDTH(VAL_W),
    .DEPTH(RF_DEPTH)
  ) u_rf (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (instr.dst),
    .wdata_i  (wdata),
    .raddr_a_i(instr.a[RF_AW-1:0]),
    .raddr_b_i(instr.b[RF_AW-1:0]),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  rbei_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      model_q     <= 2'd0;
      out_valid_q <= 1'b0;
      bind_q      <= 47'd214748365;
      unbind_q    <= 47'd4294967296;
      deact_q     <= 47'd4294967;
      dt_q        <= 33'd4294967;
      steps_q     <= 21'd100000;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_BIND:   bind_q   <= cfg_data_i;
          CFG_UNBIND: unbind_q <= cfg_data_i;
          CFG_DEACT:  deact_q  <= cfg_data_i;
          CFG_DT:     dt_q     <= cfg_data_i[32:0];
          CFG_STEPS:  steps_q  <= cfg_data_i[20:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_FETCH;
            pc_q    <= '0;
            cnt_q   <= '0;
            model_q <= 2'd0;
          end
        end
        S_FETCH: state_q <= S_EXEC;
        S_EXEC: begin
          if (instr.op == OP_MUL) begin
            state_q <= S_MULW;
          end
        end
        S_MULW: ;
        S_END: begin
          if (model_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            model_q <= model_q + 2'd1;
            pc_q    <= '0;
            cnt_q   <= '0;
            state_q <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Step to the next instruction once a result has been written.
      if (ram_we) begin
        if (pc_q == PC_INIT_LAST) begin
          if (n_eff == '0) begin
            state_q <= S_END;
          end else begin
            pc_q    <= body_pc;
            state_q <= S_FETCH;
          end
        end else if (instr.last) begin
          if (cnt_q + CNT_W'(1) == n_eff) begin
            state_q <= S_END;
          end else begin
            cnt_q   <= cnt_q + CNT_W'(1);
            pc_q    <= body_pc;
            state_q <= S_FETCH;
          end
        end else begin
          pc_q    <= pc_q + PC_W'(1);
          state_q <= S_FETCH;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      x0_q <= initial_monomer_i;
    end
    if (ram_we && instr.dst == R_P1[RF_AW-1:0]) begin
      p1_q <= wdata;
    end
    if (state_q == S_END) begin
      if (model_q == 2'd0) begin
        held0_q <= p1_q;
      end
      if (model_q == 2'd1) begin
        held1_q <= p1_q;
      end
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out0_q <= held0_q;
      out1_q <= held1_q;
      out2_q <= p1_q;
    end
  end

  // A body instruction only runs while steps remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && pc_q > PC_INIT_LAST) |-> (cnt_q < n_eff))
    else $error("step counter ran past the step count");

  // A result appears only from the completion state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");

  // The multiplier is started only when the sequencer then waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> (state_q == S_MULW && !mul_done))
    else $error("multiplier start out of sequence");

endmodule

/* verif/tb_regulator_binding_euler_integrator_top.sv */
// Self-checking testbench for regulator_binding_euler_integrator_top.
// Uses rbei_pkg for register indexes and widths. It predicts the three active
// DNA fractions of each transfer and checks them against the block's output.
module tb_regulator_binding_euler_integrator_top;
  import rbei_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam longint FX_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FX_MIN = -64'sh0000_8000_0000_0000;
  localparam logic [46:0] RATE_MAX = '1;
  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [VAL_W-1:0] monomer;
    logic [VAL_W-1:0] dimer;
    logic [VAL_W-1:0] tetramer;
  } fractions_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [46:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [46:0] initial_monomer_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [VAL_W-1:0] active_fraction_monomer_o;
  logic [VAL_W-1:0] active_fraction_dimer_o;
  logic [VAL_W-1:0] active_fraction_tetramer_o;

  // Predictor copy of the configuration.
  longint      k_bind, k_unbind, k_deact, k_dt;
  int unsigned k_steps;

  fractions_t  expected_fractions[$];
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          cfg_writes;
  bit          hold_req;

  regulator_binding_euler_integrator_top uut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Saturating fixed-point arithmetic.
  function automatic longint fx_sat(input longint v);
    if (v > FX_MAX) return FX_MAX;
    if (v < FX_MIN) return FX_MIN;
    return v;
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return fx_sat(a + b);
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    return fx_sat(a - b);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic        neg;
    logic [47:0] ma, mb;
    logic [95:0] prod;
    logic [63:0] mag, lim;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? 48'(-a) : 48'(a);
    mb   = (b < 0) ? 48'(-b) : 48'(b);
    prod = {48'b0, ma} * {48'b0, mb};
    lim  = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    mag  = (prod[95:32] > lim) ? lim : prod[95:32];
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // One forward-Euler integration of the chosen activator model.
  function automatic longint integrate(input int kind, input longint x0);
    longint      x[4], d[4];
    longint      p0, p1, rel, cap, q, s0, s1, x00, x01, x02, dp0, dp1;
    int unsigned n;
    n  = (k_steps > (1 << STEP_BITS)) ? (1 << STEP_BITS) : k_steps;
    x  = '{x0, 0, 0, 0};
    p0 = longint'(1) << FRAC_BITS;
    p1 = 0;
    for (int unsigned s = 0; s < n; s++) begin
      rel = fx_mul(p1, k_deact);
      cap = fx_mul(p0, x[(kind == 0) ? 0 : ((kind == 1) ? 1 : 3)]);
      d   = '{0, 0, 0, 0};
      if (kind == 0) begin
        d[0] = fx_sub(rel, cap);
      end else if (kind == 1) begin
        q    = fx_mul(fx_mul(k_bind, x[0]), x[0]);
        d[0] = fx_sub(fx_add(fx_mul(k_unbind, x[1]), fx_mul(k_unbind, x[1])),
                      fx_add(q, q));
        d[1] = fx_add(fx_sub(fx_sub(q, fx_mul(k_unbind, x[1])), cap), rel);
      end else begin
        s0   = fx_add(fx_add(fx_add(x[0], x[0]), x[1]), x[2]);
        s1   = fx_add(fx_add(fx_add(x[1], x[1]), x[2]), x[3]);
        x00  = fx_mul(x[0], x[0]);
        x01  = fx_mul(x[0], x[1]);
        x02  = fx_mul(x[0], x[2]);
        d[0] = fx_add(fx_sat(-fx_mul(fx_mul(k_bind, x[0]), s0)),
                      fx_mul(k_unbind, s1));
        d[1] = fx_add(fx_mul(k_bind, fx_sub(x00, x01)),
                      fx_mul(k_unbind, fx_sub(x[2], x[1])));
        d[2] = fx_add(fx_mul(k_bind, fx_sub(x01, x02)),
                      fx_mul(k_unbind, fx_sub(x[3], x[2])));
        d[3] = fx_add(fx_sub(fx_sub(fx_mul(fx_mul(k_bind, x[2]), x[0]),
                                    fx_mul(k_unbind, x[3])), cap), rel);
      end
      dp1 = fx_sub(cap, rel);
      dp0 = fx_sub(rel, cap);
      for (int i = 0; i < 4; i++) x[i] = fx_add(x[i], fx_mul(d[i], k_dt));
      p0 = fx_add(p0, fx_mul(dp0, k_dt));
      p1 = fx_add(p1, fx_mul(dp1, k_dt));
    end
    return p1;
  endfunction

  // Random gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Writes one configuration register and mirrors it in the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [46:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_BIND:   k_bind   = longint'(data);
      CFG_UNBIND: k_unbind = longint'(data);
      CFG_DEACT:  k_deact  = longint'(data);
      CFG_DT:     k_dt     = longint'(data[32:0]);
      CFG_STEPS:  k_steps  = int'(data[20:0]);
      default: ;
    endcase
  endtask

  // Offers one initial concentration and records its expected fractions.
  task automatic send_item(input logic [46:0] x0, input bit gaps);
    fractions_t f;
    int         gap;
    in_valid_i        <= 1'b1;
    initial_monomer_i <= x0;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    f.monomer  = VAL_W'(integrate(0, longint'(x0)));
    f.dimer    = VAL_W'(integrate(1, longint'(x0)));
    f.tetramer = VAL_W'(integrate(2, longint'(x0)));
    expected_fractions.push_back(f);
    items_sent++;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lowers valid and waits until every expected result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_fractions.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [46:0] rand_value(input bit wide);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return wide ? r[46:0] : 47'(r[35:0]);
  endfunction

  // Default rates, a zero and a small step count, and extreme concentrations.
  task automatic test_defaults();
    write_reg(CFG_STEPS, 47'd0);
    send_item(47'd0, 1'b1);
    send_item(RATE_MAX, 1'b1);
    send_item(47'h1_0000_0000, 1'b1);
    drain();
    write_reg(CFG_STEPS, 47'd3);
    send_item(47'd0, 1'b1);
    send_item(RATE_MAX, 1'b0);
    send_item(47'h1_0000_0000, 1'b0);
    send_item(47'h5555_5555_5555, 1'b1);
    send_item(47'h2AAA_AAAA_AAAA, 1'b1);
    drain();
  endtask

  // Largest and smallest register values, with masking of wide writes.
  task automatic test_extremes();
    write_reg(CFG_BIND, RATE_MAX);
    write_reg(CFG_UNBIND, RATE_MAX);
    write_reg(CFG_DEACT, RATE_MAX);
    write_reg(CFG_DT, 47'h1_0000_0000);
    write_reg(CFG_STEPS, 47'h7FFF_FFE0_0004);
    send_item(RATE_MAX, 1'b1);
    send_item(47'h8_0000_0000, 1'b1);
    send_item(47'd1, 1'b1);
    drain();
    write_reg(CFG_BIND, 47'd0);
    write_reg(CFG_UNBIND, 47'd0);
    write_reg(CFG_DEACT, 47'd0);
    write_reg(CFG_DT, RATE_MAX);
    write_reg(CFG_STEPS, 47'd5);
    send_item(47'h3_0000_0000, 1'b1);
    send_item(RATE_MAX, 1'b1);
    drain();
    // Unknown indexes must leave the set-up alone.
    write_reg(CFG_SPARE_LO, RATE_MAX);
    write_reg(CFG_SPARE_HI, RATE_MAX);
    // A count above the step limit is written, then replaced before any run.
    write_reg(CFG_STEPS, 47'h1F_FFFF);
    write_reg(CFG_BIND, 47'd214748365);
    write_reg(CFG_UNBIND, 47'h1_0000_0000);
    write_reg(CFG_DEACT, 47'd4294967);
    write_reg(CFG_DT, 47'h1000_0000);
    write_reg(CFG_STEPS, 47'd6);
    send_item(47'h2_0000_0000, 1'b1);
    send_item(47'h0_8000_0000, 1'b1);
    drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    write_reg(CFG_STEPS, 47'd2);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_item(rand_value($urandom_range(0, 1)), 1'b0);
    drain();
  endtask

  // Random set-ups, each followed by a batch of random concentrations.
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_BIND, $urandom_range(0, 3) == 0 ? rand_value(1) : rand_value(0));
      write_reg(CFG_UNBIND, $urandom_range(0, 3) == 0 ? rand_value(1) : rand_value(0));
      write_reg(CFG_DEACT, $urandom_range(0, 3) == 0 ? rand_value(1) : rand_value(0));
      write_reg(CFG_DT, $urandom_range(0, 3) == 0 ? rand_value(1)
                                                 : 47'($urandom_range(0, 32'h2000_0000)));
      write_reg(CFG_STEPS, (ph == 4) ? 47'd40 : 47'($urandom_range(1, 12)));
      for (int i = 0; i < 20; i++) send_item(rand_value($urandom_range(0, 1)), 1'b1);
      drain();
    end
  endtask

  // Output stall: random gaps, plus a long hold when requested.
  initial begin
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        n = pick_gap();
        out_stall_i <= (n > 0);
        repeat ((n > 0) ? n : 1) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    fractions_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_fractions.size() == 0) begin
        $display("%0t: result with nothing expected: %h %h %h", $time,
                 active_fraction_monomer_o, active_fraction_dimer_o,
                 active_fraction_tetramer_o);
        error_count++;
      end else begin
        e = expected_fractions.pop_front();
        if (active_fraction_monomer_o !== e.monomer) begin
          $display("%0t: monomer fraction expected %h actual %h", $time,
                   e.monomer, active_fraction_monomer_o);
          error_count++;
        end
        if (active_fraction_dimer_o !== e.dimer) begin
          $display("%0t: dimer fraction expected %h actual %h", $time,
                   e.dimer, active_fraction_dimer_o);
          error_count++;
        end
        if (active_fraction_tetramer_o !== e.tetramer) begin
          $display("%0t: tetramer fraction expected %h actual %h", $time,
                   e.tetramer, active_fraction_tetramer_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle);
        $display("regulator_binding_euler_integrator_top test failed");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CFG_BIND;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    initial_monomer_i = '0;
    hold_req          = 1'b0;
    error_count       = 0;
    items_sent        = 0;
    results_seen      = 0;
    cfg_writes        = 0;
    k_bind            = 214748365;
    k_unbind          = 64'h1_0000_0000;
    k_deact           = 4294967;
    k_dt              = 4294967;
    k_steps           = 100000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_backpressure();
    test_random();
    $display("Covered %0d concentrations, %0d results and %0d register writes,",
             items_sent, results_seen, cfg_writes);
    $display("including zero steps, saturating rates and a long output hold.");
    if (error_count == 0 && expected_fractions.size() == 0) begin
      $display("regulator_binding_euler_integrator_top test passed");
    end else begin
      $display("regulator_binding_euler_integrator_top test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rbei_pkg.sv
src/rbei_ram.sv
src/rbei_mul.sv
src/regulator_binding_euler_integrator_top.sv
verif/tb_regulator_binding_euler_integrator_top.sv
